// ----- hw/rtl/nti_pkg.sv -----
// Shared types and codes of the neighbour table insert core
package nti_pkg;

   localparam int FUNC_W   = 2;
   localparam int MSG_W    = 8;
   localparam int ADDR_W   = 16;
   localparam int RSSI_W   = 8;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef logic [FUNC_W-1:0]          func_type;
   typedef logic [MSG_W-1:0]           msg_type_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic signed [RSSI_W-1:0]   rssi_type;
   typedef logic [INDEX_W-1:0]         index_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [COUNT_W-1:0]         count_type;

   localparam func_type FUNC_MESSAGE = 2'd0;
   localparam func_type FUNC_CLEAR   = 2'd1;
   localparam func_type FUNC_READ    = 2'd2;

   localparam msg_type_type MT_HELLO     = 8'd1;
   localparam msg_type_type MT_HELLO_ACK = 8'd2;

   localparam status_type STATUS_ADDED     = 3'd0;
   localparam status_type STATUS_KNOWN     = 3'd1;
   localparam status_type STATUS_FULL      = 3'd2;
   localparam status_type STATUS_WEAK      = 3'd3;
   localparam status_type STATUS_IGNORED   = 3'd4;
   localparam status_type STATUS_CLEARED   = 3'd5;
   localparam status_type STATUS_READ_OK   = 3'd6;
   localparam status_type STATUS_BAD_INDEX = 3'd7;

   localparam rssi_type THRESHOLD_RESET = -8'sd70;

endpackage

// ----- hw/rtl/nti_if.sv -----
// Request and response channel interfaces of the neighbour table insert core
interface nti_req_if;
   logic                      valid;
   logic                      ready;
   nti_pkg::func_type         func;
   nti_pkg::msg_type_type     msg_type;
   nti_pkg::addr_type         sender_addr;
   nti_pkg::rssi_type         signal_strength;
   nti_pkg::index_type        entry_index;

   modport source (output valid, func, msg_type, sender_addr, signal_strength, entry_index,
                   input ready);
   modport sink   (input valid, func, msg_type, sender_addr, signal_strength, entry_index,
                   output ready);
endinterface

interface nti_rsp_if;
   logic                      valid;
   logic                      ready;
   nti_pkg::status_type       status;
   logic                      send_ack;
   nti_pkg::addr_type         ack_addr;
   nti_pkg::addr_type         read_addr;
   nti_pkg::count_type        neighbour_count;

   modport source (output valid, status, send_ack, ack_addr, read_addr, neighbour_count,
                   input ready);
   modport sink   (input valid, status, send_ack, ack_addr, read_addr, neighbour_count,
                   output ready);
endinterface

// ----- hw/rtl/nti_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module nti_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/neighbour_table_insert_core.sv -----
// Neighbour table insert core: top level with sequencer, count and result register
//
//  channel    dir  handshake        payload
//  req_bus    in   valid / ready    func, msg_type, sender_addr, signal_strength, entry_index
//  rsp_bus    out  valid / ready    status, send_ack, ack_addr, read_addr, neighbour_count
//  csr_*      in   write enable     signal_threshold (signed 8 bit)
//
// A beat that searches the table steps through ST_SEARCH up to the result register: the
// search reads one entry a cycle through the single RAM read port, one compare per entry.
// Reads pass ST_RD_ADDR, ST_RD_DATA; others go to ST_RESULT. One beat is in work at a time.
// Reset empties the table by zeroing the count; no clearing pass is needed.
// A finished result waits in the output register while the next beat is taken; it only
// holds the sequencer when the previous response has not yet been taken.
module neighbour_table_insert_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   nti_req_if.sink                 req_bus,
   nti_rsp_if.source               rsp_bus,
   input  logic                    csr_wr_en,
   input  nti_pkg::rssi_type       csr_wr_data
);

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int IW  = (CW > nti_pkg::INDEX_W) ? CW : nti_pkg::INDEX_W;
   localparam int NCW = (CW > nti_pkg::COUNT_W) ? CW : nti_pkg::COUNT_W;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SEARCH  = 5'b00010,
      ST_RD_ADDR = 5'b00100,
      ST_RD_DATA = 5'b01000,
      ST_RESULT  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   nti_pkg::rssi_type      thr_ff, thr_in;
   nti_pkg::addr_type      key_ff, key_in;
   logic                   hello_ff, hello_in;
   nti_pkg::index_type     idx_ff, idx_in;
   nti_pkg::status_type    res_status_ff, res_status_in;
   logic                   res_ack_ff, res_ack_in;
   nti_pkg::addr_type      res_read_ff, res_read_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   nti_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic                   rsp_ack_ff, rsp_ack_in;
   nti_pkg::addr_type      rsp_ack_addr_ff, rsp_ack_addr_in;
   nti_pkg::addr_type      rsp_read_ff, rsp_read_in;
   nti_pkg::count_type     rsp_count_ff, rsp_count_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_rd_addr;
   nti_pkg::addr_type      ram_rd_data;
   logic                   match;
   logic [IW-1:0]          req_idx_w, idx_w, count_iw;
   logic [NCW-1:0]         count_nw;

   nti_ram #(
      .WIDTH (nti_pkg::ADDR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_idx_w   = IW'(req_bus.entry_index);
   assign idx_w       = IW'(idx_ff);
   assign count_iw    = IW'(count_ff);
   assign count_nw    = NCW'(count_ff);
   assign ram_rd_addr = (state_ff == ST_SEARCH) ? ptr_ff[AW-1:0] : idx_w[AW-1:0];
   // read data is registered and belongs to the address of the cycle before
   assign match       = cmp_vld_ff && (ram_rd_data == key_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      cmp_vld_in      = 1'b0;
      thr_in          = csr_wr_en ? csr_wr_data : thr_ff;
      key_in          = key_ff;
      hello_in        = hello_ff;
      idx_in          = idx_ff;
      res_status_in   = res_status_ff;
      res_ack_in      = res_ack_ff;
      res_read_in     = res_read_ff;
      ram_wr_en       = 1'b0;

      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_ack_in      = rsp_ack_ff;
      rsp_ack_addr_in = rsp_ack_addr_ff;
      rsp_read_in     = rsp_read_ff;
      rsp_count_in    = rsp_count_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               key_in        = req_bus.sender_addr;
               hello_in      = (req_bus.msg_type == nti_pkg::MT_HELLO);
               idx_in        = req_bus.entry_index;
               ptr_in        = '0;
               res_status_in = nti_pkg::STATUS_IGNORED;
               res_ack_in    = 1'b0;
               res_read_in   = '0;
               state_in      = ST_RESULT;
               unique case (req_bus.func)
                  nti_pkg::FUNC_MESSAGE: begin
                     if (req_bus.msg_type == nti_pkg::MT_HELLO) begin
                        if (req_bus.signal_strength > thr_ff) begin
                           if (req_bus.sender_addr != '0) begin
                              state_in = ST_SEARCH;
                           end
                        end else begin
                           res_status_in = nti_pkg::STATUS_WEAK;
                        end
                     end else if (req_bus.msg_type == nti_pkg::MT_HELLO_ACK) begin
                        if (req_bus.sender_addr != '0) begin
                           state_in = ST_SEARCH;
                        end
                     end
                  end
                  nti_pkg::FUNC_CLEAR: begin
                     count_in      = '0;
                     res_status_in = nti_pkg::STATUS_CLEARED;
                  end
                  nti_pkg::FUNC_READ: begin
                     if (req_idx_w < count_iw) begin
                        state_in = ST_RD_ADDR;
                     end else begin
                        res_status_in = nti_pkg::STATUS_BAD_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (match) begin
               res_status_in = nti_pkg::STATUS_KNOWN;
               state_in      = ST_RESULT;
            end else if (ptr_ff == count_ff) begin
               // every stored entry compared, none equal
               if (count_ff == CW'(TABLE_DEPTH)) begin
                  res_status_in = nti_pkg::STATUS_FULL;
               end else begin
                  ram_wr_en     = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = nti_pkg::STATUS_ADDED;
                  res_ack_in    = hello_ff;
               end
               state_in = ST_RESULT;
            end else begin
               ptr_in     = ptr_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            res_read_in   = ram_rd_data;
            res_status_in = nti_pkg::STATUS_READ_OK;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_ack_in      = res_ack_ff;
               rsp_ack_addr_in = res_ack_ff ? key_ff : '0;
               rsp_read_in     = res_read_ff;
               rsp_count_in    = count_nw[nti_pkg::COUNT_W-1:0];
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= nti_pkg::THRESHOLD_RESET;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      key_ff          <= key_in;
      hello_ff        <= hello_in;
      idx_ff          <= idx_in;
      res_status_ff   <= res_status_in;
      res_ack_ff      <= res_ack_in;
      res_read_ff     <= res_read_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_ack_ff      <= rsp_ack_in;
      rsp_ack_addr_ff <= rsp_ack_addr_in;
      rsp_read_ff     <= rsp_read_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.send_ack        = rsp_ack_ff;
   assign rsp_bus.ack_addr        = rsp_ack_addr_ff;
   assign rsp_bus.read_addr       = rsp_read_ff;
   assign rsp_bus.neighbour_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("neighbour count beyond table depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (count_ff < CW'(TABLE_DEPTH)) && (state_ff == ST_SEARCH))
      else $error("table write without room or outside search");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(ram_wr_en) || (count_ff == '0)))
      else $error("neighbour count changed without insert or clear");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result state");

   a_ack_added: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ack_ff) |-> (rsp_status_ff == nti_pkg::STATUS_ADDED))
      else $error("acknowledge requested for a beat that added nothing");
`endif

endmodule

// ----- test/neighbour_table_checker.sv -----
`timescale 1ns / 100ps
// Checker for the neighbour table insert core: tracks the table and compares every response beat
module neighbour_table_checker (
   input  logic               clock,
   input  logic               reset,
   nti_req_if                 req_mon,
   nti_rsp_if                 rsp_mon,
   input  logic               csr_wr_en,
   input  nti_pkg::rssi_type  csr_wr_data,
   output int                 failures,
   output int                 outstanding,
   output int                 checked
);

   localparam int DEPTH       = 64;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      nti_pkg::status_type status;
      logic                send_ack;
      nti_pkg::addr_type   ack_addr;
      nti_pkg::addr_type   read_addr;
      nti_pkg::count_type  neighbours;
   } table_reply_type;

   nti_pkg::addr_type  neighbour_tbl [DEPTH];
   int                 neighbour_total;
   nti_pkg::rssi_type  hello_threshold;
   table_reply_type    reply_queue [$];

   // search the filled part, append on a miss while room is left
   function automatic nti_pkg::status_type insert_neighbour(nti_pkg::addr_type addr);
      for (int i = 0; i < neighbour_total; i++) begin
         if (neighbour_tbl[i] == addr) return nti_pkg::STATUS_KNOWN;
      end
      if (neighbour_total >= DEPTH) return nti_pkg::STATUS_FULL;
      neighbour_tbl[neighbour_total] = addr;
      neighbour_total++;
      return nti_pkg::STATUS_ADDED;
   endfunction

   function automatic table_reply_type table_step(nti_pkg::func_type fn,
                                                  nti_pkg::msg_type_type msg,
                                                  nti_pkg::addr_type addr,
                                                  nti_pkg::rssi_type rssi,
                                                  nti_pkg::index_type idx);
      table_reply_type rep;
      rep = '0;
      rep.status = nti_pkg::STATUS_IGNORED;
      case (fn)
         nti_pkg::FUNC_MESSAGE: begin
            if (msg == nti_pkg::MT_HELLO) begin
               if (rssi > hello_threshold) begin
                  if (addr != '0) begin
                     rep.status = insert_neighbour(addr);
                     if (rep.status == nti_pkg::STATUS_ADDED) begin
                        rep.send_ack = 1'b1;
                        rep.ack_addr = addr;
                     end
                  end
               end else begin
                  rep.status = nti_pkg::STATUS_WEAK;
               end
            end else if (msg == nti_pkg::MT_HELLO_ACK && addr != '0) begin
               rep.status = insert_neighbour(addr);
            end
         end
         nti_pkg::FUNC_CLEAR: begin
            neighbour_total = 0;
            rep.status = nti_pkg::STATUS_CLEARED;
         end
         nti_pkg::FUNC_READ: begin
            if (int'(idx) < neighbour_total) begin
               rep.read_addr = neighbour_tbl[idx];
               rep.status = nti_pkg::STATUS_READ_OK;
            end else begin
               rep.status = nti_pkg::STATUS_BAD_INDEX;
            end
         end
         default: rep.status = nti_pkg::STATUS_IGNORED;
      endcase
      rep.neighbours = nti_pkg::count_type'(neighbour_total);
      return rep;
   endfunction

   always @(posedge clock) begin
      table_reply_type want;
      table_reply_type got;
      if (reset) begin
         neighbour_total = 0;
         hello_threshold = nti_pkg::THRESHOLD_RESET;
         reply_queue.delete();
         failures = 0;
         checked = 0;
      end else begin
         if (csr_wr_en) hello_threshold = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            reply_queue.push_back(table_step(req_mon.func, req_mon.msg_type, req_mon.sender_addr,
                                             req_mon.signal_strength, req_mon.entry_index));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.status, rsp_mon.send_ack, rsp_mon.ack_addr, rsp_mon.read_addr,
                    rsp_mon.neighbour_count};
            checked++;
            if (reply_queue.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: response beat with nothing pending: status %0d count %0d",
                           $realtime, got.status, got.neighbours);
            end else begin
               want = reply_queue.pop_front();
               if (want != got) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("%0t: mismatch on response %0d", $realtime, checked);
                     $display("   expected status %0d ack %0b ack_addr %h read_addr %h count %0d",
                              want.status, want.send_ack, want.ack_addr, want.read_addr,
                              want.neighbours);
                     $display("   got      status %0d ack %0b ack_addr %h read_addr %h count %0d",
                              got.status, got.send_ack, got.ack_addr, got.read_addr,
                              got.neighbours);
                  end
               end
            end
         end
      end
      outstanding = reply_queue.size();
   end

endmodule

// ----- test/tb_neighbour_table_insert_core.sv -----
`timescale 1ns / 100ps
// Testbench top for the neighbour table insert core: clock, reset, stimulus and verdict
module tb_neighbour_table_insert_core;

   localparam int ITEM_TARGET = 1150;
   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int HOLD_CYCLES = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   nti_pkg::rssi_type csr_wr_data = '0;

   int fail_count;
   int outstanding;
   int checked_count;
   int cycle_count = 0;
   int beats_sent = 0;
   int phase = 0;
   int fills = 0;
   int threshold_writes = 0;
   int hold_request = 0;
   bit steady = 1'b0;

   nti_pkg::rssi_type cur_threshold = nti_pkg::THRESHOLD_RESET;
   nti_pkg::addr_type addr_pool [16];

   nti_req_if req_bus ();
   nti_rsp_if rsp_bus ();

   neighbour_table_insert_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   neighbour_table_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (fail_count),
      .outstanding (outstanding),
      .checked     (checked_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, outstanding);
         $display("== FAIL ==");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (steady || p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // response side: random stalls plus one long hold-off on request
   initial begin
      int long_hold_left;
      int stall_left;
      long_hold_left = 0;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            long_hold_left = hold_request;
            hold_request = 0;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = (!steady && $urandom_range(3) == 0) ? pick_gap() : 0;
         end
      end
   end

   task automatic send_beat(input nti_pkg::func_type fn, input nti_pkg::msg_type_type msg,
                            input nti_pkg::addr_type addr, input nti_pkg::rssi_type rssi,
                            input nti_pkg::index_type idx);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.func            <= fn;
      req_bus.msg_type        <= msg;
      req_bus.sender_addr     <= addr;
      req_bus.signal_strength <= rssi;
      req_bus.entry_index     <= idx;
      req_bus.valid           <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   // stop offering and wait for every pending response beat
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic send_mixed_beat();
      int                p;
      int                r;
      nti_pkg::addr_type addr;
      p = $urandom_range(99);
      addr = ($urandom_range(9) < 7) ? addr_pool[$urandom_range(15)]
                                     : nti_pkg::addr_type'($urandom);
      if ($urandom_range(1)) begin
         // near the threshold, clamped to the field range
         r = int'(cur_threshold) + int'($urandom_range(4)) - 2;
         if (r > 127) r = 127;
         if (r < -128) r = -128;
      end else begin
         r = int'(nti_pkg::rssi_type'($urandom));
      end
      if (p < 40)
         send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, addr, nti_pkg::rssi_type'(r),
                   nti_pkg::index_type'($urandom));
      else if (p < 60)
         send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO_ACK, addr, nti_pkg::rssi_type'(r),
                   nti_pkg::index_type'($urandom));
      else if (p < 75)
         send_beat(nti_pkg::FUNC_READ, nti_pkg::msg_type_type'($urandom),
                   nti_pkg::addr_type'($urandom), nti_pkg::rssi_type'($urandom),
                   ($urandom_range(9) < 7) ? nti_pkg::index_type'($urandom_range(15))
                                           : nti_pkg::index_type'($urandom));
      else if (p < 78)
         send_beat(nti_pkg::FUNC_CLEAR, nti_pkg::msg_type_type'($urandom),
                   nti_pkg::addr_type'($urandom), nti_pkg::rssi_type'($urandom),
                   nti_pkg::index_type'($urandom));
      else if (p < 84)
         send_beat(nti_pkg::FUNC_MESSAGE,
                   $urandom_range(1) ? nti_pkg::MT_HELLO : nti_pkg::MT_HELLO_ACK, '0,
                   nti_pkg::rssi_type'(r), nti_pkg::index_type'($urandom));
      else if (p < 94)
         send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::msg_type_type'($urandom), addr,
                   nti_pkg::rssi_type'(r), nti_pkg::index_type'($urandom));
      else
         send_beat(nti_pkg::func_type'(3), nti_pkg::msg_type_type'($urandom),
                   nti_pkg::addr_type'($urandom), nti_pkg::rssi_type'($urandom),
                   nti_pkg::index_type'($urandom));
   endtask

   initial begin
      nti_pkg::rssi_type thr_sweep [6];
      nti_pkg::rssi_type thr;
      nti_pkg::addr_type addr;
      int                r;
      int                style;
      int                n;

      thr_sweep = '{nti_pkg::rssi_type'(-128), nti_pkg::rssi_type'(127),
                    nti_pkg::rssi_type'(-1), nti_pkg::rssi_type'(0),
                    nti_pkg::rssi_type'(-70), nti_pkg::rssi_type'(1)};
      req_bus.valid           = 1'b0;
      req_bus.func            = nti_pkg::FUNC_MESSAGE;
      req_bus.msg_type        = '0;
      req_bus.sender_addr     = '0;
      req_bus.signal_strength = '0;
      req_bus.entry_index     = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset threshold of -70
      send_beat(nti_pkg::FUNC_READ, '0, '0, '0, '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'h0001,
                nti_pkg::rssi_type'(127), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'h0001,
                nti_pkg::rssi_type'(127), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'hFFFF,
                nti_pkg::rssi_type'(-69), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'h1234,
                nti_pkg::rssi_type'(-70), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'h2222,
                nti_pkg::rssi_type'(-128), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'h0000,
                nti_pkg::rssi_type'(0), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'h0000,
                nti_pkg::rssi_type'(-100), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO_ACK, 16'h8000,
                nti_pkg::rssi_type'(-128), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO_ACK, 16'h0000,
                nti_pkg::rssi_type'(127), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO_ACK, 16'h0001,
                nti_pkg::rssi_type'(-128), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, 8'd0,   16'h5555, nti_pkg::rssi_type'(127), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, 8'd3,   16'h5555, nti_pkg::rssi_type'(127), '0);
      send_beat(nti_pkg::FUNC_MESSAGE, 8'd255, 16'hAAAA, nti_pkg::rssi_type'(127), 6'h3F);
      send_beat(nti_pkg::func_type'(3), nti_pkg::MT_HELLO, 16'h4321,
                nti_pkg::rssi_type'(127), '0);
      send_beat(nti_pkg::FUNC_READ,  '0, '0, '0, 6'd0);
      send_beat(nti_pkg::FUNC_READ,  '0, '0, '0, 6'd2);
      send_beat(nti_pkg::FUNC_READ,  '0, '0, '0, 6'd3);
      send_beat(nti_pkg::FUNC_READ,  '0, '0, '0, 6'd63);
      send_beat(nti_pkg::FUNC_CLEAR, '0, '0, '0, '0);
      send_beat(nti_pkg::FUNC_READ,  '0, '0, '0, 6'd0);
      send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, 16'h0001,
                nti_pkg::rssi_type'(127), '0);

      while (beats_sent < ITEM_TARGET) begin
         drain();
         thr = (phase < 6) ? thr_sweep[phase] : nti_pkg::rssi_type'($urandom);
         csr_wr_data <= thr;
         csr_wr_en   <= 1'b1;
         @(negedge clock);
         csr_wr_en   <= 1'b0;
         cur_threshold = thr;
         threshold_writes++;
         foreach (addr_pool[i]) addr_pool[i] = nti_pkg::addr_type'($urandom_range(1, 65535));

         if (phase < 3) style = phase;
         else begin
            r = $urandom_range(9);
            style = (r < 2) ? 0 : (r == 2) ? 2 : 3;
         end

         case (style)
            0: begin
               // fill to the brim, then probe the full table
               send_beat(nti_pkg::FUNC_CLEAR, nti_pkg::msg_type_type'($urandom),
                         nti_pkg::addr_type'($urandom), nti_pkg::rssi_type'($urandom),
                         nti_pkg::index_type'($urandom));
               addr = '0;
               for (int i = 0; i < 72; i++) begin
                  addr = nti_pkg::addr_type'($urandom_range(1, 65535));
                  if (cur_threshold != nti_pkg::rssi_type'(127) && $urandom_range(1)) begin
                     r = 127 - int'($urandom_range(126 - int'(cur_threshold)));
                     send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO, addr,
                               nti_pkg::rssi_type'(r), nti_pkg::index_type'($urandom));
                  end else begin
                     send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO_ACK, addr,
                               nti_pkg::rssi_type'($urandom), nti_pkg::index_type'($urandom));
                  end
               end
               send_beat(nti_pkg::FUNC_MESSAGE, nti_pkg::MT_HELLO_ACK, addr,
                         nti_pkg::rssi_type'($urandom), '0);
               repeat (4)
                  send_beat(nti_pkg::FUNC_READ, nti_pkg::msg_type_type'($urandom),
                            nti_pkg::addr_type'($urandom), nti_pkg::rssi_type'($urandom),
                            nti_pkg::index_type'($urandom_range(56, 63)));
               fills++;
            end
            1: begin
               // receiver holds off while the sender keeps offering
               steady = 1'b1;
               hold_request = HOLD_CYCLES;
               repeat (40) send_mixed_beat();
               steady = 1'b0;
            end
            2: begin
               steady = 1'b1;
               repeat (80) send_mixed_beat();
               steady = 1'b0;
            end
            default: begin
               n = $urandom_range(40, 90);
               repeat (n) send_mixed_beat();
            end
         endcase
         phase++;
      end

      drain();
      repeat (100) @(posedge clock);

      $display("%0d request beats in %0d phases, %0d responses checked, %0d mismatches",
               beats_sent, phase, checked_count, fail_count);
      $display("%0d threshold settings, table filled %0d times", threshold_writes, fills);
      if (fail_count == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
